@@ sv/mcld_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mcld_pkg;

  // line store geometry
  localparam int LINE_BYTES = 20;
  localparam int IDX_W      = $clog2(LINE_BYTES);

  // byte codes
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_STOP  = 8'h73;
  localparam logic [7:0] CHR_BRAKE = 8'h65;
  localparam logic [7:0] CHR_FWD   = 8'h66;
  localparam logic [7:0] CHR_BACK  = 8'h62;
  localparam logic [7:0] CHR_NUL   = 8'h00;

  // fixed positions inside a drive line
  localparam logic [IDX_W-1:0] LEFT_DIR_POS    = IDX_W'(0);
  localparam logic [IDX_W-1:0] LEFT_SPEED_POS  = IDX_W'(2);
  localparam logic [IDX_W-1:0] RIGHT_DIR_POS   = IDX_W'(4);
  localparam logic [IDX_W-1:0] RIGHT_SPEED_POS = IDX_W'(6);
  localparam logic [IDX_W-1:0] SINGLE_LEN      = IDX_W'(1);
  localparam logic [IDX_W-1:0] DRIVE_MIN_LEN   = IDX_W'(5);

  // speed range, saturation marks an overlong digit run
  localparam int SPEED_W = 4;
  localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(9);
  localparam logic [SPEED_W-1:0] SPEED_SAT = SPEED_W'(10);

  // duty arithmetic: x / 10 == (x * 6554) >> 16 for x below 16384
  localparam int DUTY_W  = 8;
  localparam int SCALE_W = 8;
  localparam int PROD_W  = SPEED_W + SCALE_W;
  localparam int RECIP_W = 13;
  localparam int RECIP_SH = 16;
  localparam logic [RECIP_W-1:0] DIV10_RECIP = RECIP_W'(6554);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(49);

  typedef enum logic [2:0] {
    KIND_STOP           = 3'd0,
    KIND_BRAKE          = 3'd1,
    KIND_DRIVE          = 3'd2,
    KIND_UNKNOWN_SINGLE = 3'd3,
    KIND_INVALID        = 3'd4,
    KIND_UNKNOWN_FORMAT = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL_L,
    ST_DIV_L,
    ST_MUL_R,
    ST_DIV_R,
    ST_EMIT
  } seq_state_t;

  typedef enum logic [1:0] {
    PS_BLANK,
    PS_DIGIT,
    PS_DONE
  } parse_state_t;

  // line store control from the sequencer
  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             clear;
  } ls_ctrl_t;

  // one byte read back from the line store
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] pos;
    logic [7:0]       data;
  } rd_beat_t;

  typedef struct packed {
    logic mul_en;
    logic div_en;
  } duty_ctrl_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_NINE);
  endfunction

endpackage

`default_nettype wire

@@ sv/mcld_rx_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mcld_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ sv/mcld_cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mcld_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty_scale_tenths;

  modport source (output valid, output duty_scale_tenths, input ready);
  modport sink (input valid, input duty_scale_tenths, output ready);
endinterface

`default_nettype wire

@@ sv/mcld_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface mcld_result_if;
  import mcld_pkg::*;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic       left_reverse;
  logic [7:0] l_duty;
  logic       right_reverse;
  logic [7:0] r_duty;

  modport source (output valid, output kind, output left_reverse, output l_duty,
                  output right_reverse, output r_duty, input ready);
  modport sink (input valid, input kind, input left_reverse, input l_duty,
                input right_reverse, input r_duty, output ready);
endinterface

`default_nettype wire

@@ sv/motor_command_line_decoder_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// data bytes: written into the line store at the fill count while it has room
// line end: the line store is scanned through its single registered read port, then
//   the left and right duties are computed and the result is loaded into the output register
// no new byte is taken from a line end until the result sits in the output register
// reset (synchronous, active high): empty line, duty scale 49, no result pending
module motor_command_line_decoder_core (
  input  wire logic    clk,
  input  wire logic    rst,
  mcld_rx_if.sink      rx,
  mcld_cfg_if.sink     cfg,
  mcld_result_if.source cmd
);
  import mcld_pkg::*;

  seq_state_t       state;
  seq_state_t       state_next;
  logic [IDX_W-1:0] scan_idx;
  logic             scan_last;

  logic             rx_xfer;
  logic             is_term;
  logic             line_start;

  ls_ctrl_t         ls_ctrl;
  rd_beat_t         beat;
  duty_ctrl_t       duty_ctrl;

  logic [SCALE_W-1:0] scale;
  logic [IDX_W-1:0] line_len;
  logic             len_found;
  logic [7:0]       l_dir;
  logic [7:0]       r_dir;

  logic [SPEED_W-1:0] l_speed;
  logic [SPEED_W-1:0] r_speed;
  logic             left_ok;
  logic             right_ok;
  logic [SPEED_W-1:0] mul_speed;
  logic [DUTY_W-1:0]  duty;
  logic [DUTY_W-1:0]  l_duty_hold;

  logic             out_free;
  logic             out_load;
  logic             out_valid;
  kind_t            kind_next;
  logic             dirs_ok;

  // input side
  assign rx.ready   = state == ST_IDLE;
  assign rx_xfer    = rx.valid && rx.ready;
  assign is_term    = (rx.rx_byte == CHR_LF) || (rx.rx_byte == CHR_CR);
  assign line_start = rx_xfer && is_term;
  assign scan_last  = scan_idx == IDX_W'(LINE_BYTES - 1);

  // the scale register takes a write at any time
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      scale <= cfg.duty_scale_tenths;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (line_start) state_next = ST_SCAN;
      ST_SCAN:  if (scan_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_MUL_L;
      ST_MUL_L: state_next = ST_DIV_L;
      ST_DIV_L: state_next = ST_MUL_R;
      ST_MUL_R: state_next = ST_DIV_R;
      ST_DIV_R: state_next = ST_EMIT;
      ST_EMIT:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ls_ctrl.wr_en  = rx_xfer && !is_term;
    ls_ctrl.rd_en  = 1'b0;
    ls_ctrl.rd_idx = scan_idx;
    ls_ctrl.clear  = 1'b0;
    duty_ctrl.mul_en = 1'b0;
    duty_ctrl.div_en = 1'b0;
    mul_speed = l_speed;
    out_load  = 1'b0;
    case (state)
      ST_SCAN:  ls_ctrl.rd_en = 1'b1;
      // last byte is already in the read register, so the line can go
      ST_DRAIN: ls_ctrl.clear = 1'b1;
      ST_MUL_L: duty_ctrl.mul_en = 1'b1;
      ST_DIV_L: duty_ctrl.div_en = 1'b1;
      ST_MUL_R: begin
        duty_ctrl.mul_en = 1'b1;
        mul_speed = r_speed;
      end
      ST_DIV_R: duty_ctrl.div_en = 1'b1;
      ST_EMIT:  out_load = out_free;
      default:  ls_ctrl.rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        scan_idx <= scan_last ? '0 : scan_idx + IDX_W'(1);
      end
    end
  end

  mcld_line_store u_store (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ls_ctrl),
    .wr_byte (rx.rx_byte),
    .beat    (beat)
  );

  mcld_speed_parse u_left_parse (
    .clk       (clk),
    .rst       (rst),
    .restart   (line_start),
    .start_pos (LEFT_SPEED_POS),
    .beat      (beat),
    .speed     (l_speed),
    .ok        (left_ok)
  );

  mcld_speed_parse u_right_parse (
    .clk       (clk),
    .rst       (rst),
    .restart   (line_start),
    .start_pos (RIGHT_SPEED_POS),
    .beat      (beat),
    .speed     (r_speed),
    .ok        (right_ok)
  );

  mcld_duty_unit u_duty (
    .clk   (clk),
    .ctrl  (duty_ctrl),
    .speed (mul_speed),
    .scale (scale),
    .duty  (duty)
  );

  // line length is the first zero byte; the last entry is never written,
  // so a zero always turns up within the scan
  always_ff @(posedge clk) begin
    if (line_start) begin
      len_found <= 1'b0;
      line_len  <= '0;
    end else if (beat.valid && !len_found && (beat.data == CHR_NUL)) begin
      len_found <= 1'b1;
      line_len  <= beat.pos;
    end
    if (beat.valid && (beat.pos == LEFT_DIR_POS)) begin
      l_dir <= beat.data;
    end
    if (beat.valid && (beat.pos == RIGHT_DIR_POS)) begin
      r_dir <= beat.data;
    end
    if (state == ST_MUL_R) begin
      l_duty_hold <= duty;
    end
  end

  // result classification
  assign dirs_ok = ((l_dir == CHR_FWD) || (l_dir == CHR_BACK)) &&
                   ((r_dir == CHR_FWD) || (r_dir == CHR_BACK));

  always_comb begin
    if (line_len == SINGLE_LEN) begin
      if (l_dir == CHR_STOP) begin
        kind_next = KIND_STOP;
      end else if (l_dir == CHR_BRAKE) begin
        kind_next = KIND_BRAKE;
      end else begin
        kind_next = KIND_UNKNOWN_SINGLE;
      end
    end else if (line_len < DRIVE_MIN_LEN) begin
      kind_next = KIND_UNKNOWN_FORMAT;
    end else if (!left_ok || !right_ok || !dirs_ok) begin
      kind_next = KIND_INVALID;
    end else begin
      kind_next = KIND_DRIVE;
    end
  end

  // output register: holds one result until its transfer
  assign out_free  = !out_valid || cmd.ready;
  assign cmd.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (cmd.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cmd.kind <= kind_next;
      if (kind_next == KIND_DRIVE) begin
        cmd.left_reverse  <= l_dir == CHR_BACK;
        cmd.l_duty        <= l_duty_hold;
        cmd.right_reverse <= r_dir == CHR_BACK;
        cmd.r_duty        <= duty;
      end else begin
        cmd.left_reverse  <= 1'b0;
        cmd.l_duty        <= '0;
        cmd.right_reverse <= 1'b0;
        cmd.r_duty        <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/mcld_line_store.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mcld_line_store (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mcld_pkg::ls_ctrl_t ctrl,
  input  wire logic [7:0]         wr_byte,
  output mcld_pkg::rd_beat_t      beat
);
  import mcld_pkg::*;

  logic [7:0]       mem [LINE_BYTES];
  logic [IDX_W-1:0] fill_count;
  logic [7:0]       rd_data;
  logic             rd_zero;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_pos;
  logic             has_room;

  assign has_room = fill_count < IDX_W'(LINE_BYTES - 1);

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && has_room) begin
      mem[fill_count] <= wr_byte;
    end
    rd_data <= mem[ctrl.rd_idx];
    // entries at or past the fill count read back as zero, whatever they still hold
    rd_zero <= ctrl.rd_idx >= fill_count;
    rd_pos  <= ctrl.rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      rd_valid   <= 1'b0;
    end else begin
      rd_valid <= ctrl.rd_en;
      if (ctrl.clear) begin
        fill_count <= '0;
      end else if (ctrl.wr_en && has_room) begin
        fill_count <= fill_count + IDX_W'(1);
      end
    end
  end

  always_comb begin
    beat.valid = rd_valid;
    beat.pos   = rd_pos;
    beat.data  = rd_zero ? CHR_NUL : rd_data;
  end

endmodule

`default_nettype wire

@@ sv/mcld_speed_parse.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mcld_speed_parse (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            restart,
  input  wire logic [mcld_pkg::IDX_W-1:0]      start_pos,
  input  wire mcld_pkg::rd_beat_t              beat,
  output logic [mcld_pkg::SPEED_W-1:0]         speed,
  output logic                                 ok
);
  import mcld_pkg::*;

  parse_state_t     state;
  parse_state_t     state_next;
  logic [SPEED_W-1:0] mag;
  logic [SPEED_W-1:0] mag_next;
  logic             neg;
  logic             neg_next;
  logic             active;
  logic             c_blank;
  logic             c_digit;
  logic             c_sign;
  logic [SPEED_W-1:0] c_val;

  assign active  = beat.valid && (beat.pos >= start_pos);
  assign c_blank = is_blank(beat.data);
  assign c_digit = is_digit(beat.data);
  assign c_sign  = (beat.data == CHR_PLUS) || (beat.data == CHR_MINUS);
  assign c_val   = beat.data[SPEED_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      PS_BLANK: begin
        if (active && !c_blank) begin
          state_next = (c_sign || c_digit) ? PS_DIGIT : PS_DONE;
        end
      end
      PS_DIGIT: begin
        if (active && !c_digit) begin
          state_next = PS_DONE;
        end
      end
      PS_DONE: state_next = PS_DONE;
      default: state_next = PS_DONE;
    endcase
  end

  always_comb begin
    mag_next = mag;
    neg_next = neg;
    case (state)
      PS_BLANK: begin
        if (active && c_sign) begin
          neg_next = beat.data == CHR_MINUS;
        end else if (active && c_digit) begin
          mag_next = c_val;
        end
      end
      PS_DIGIT: begin
        // a second nonzero digit place can only push past nine
        if (active && c_digit) begin
          mag_next = (mag == '0) ? c_val : SPEED_SAT;
        end
      end
      default: begin
        mag_next = mag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= PS_BLANK;
      mag   <= '0;
      neg   <= 1'b0;
    end else begin
      state <= state_next;
      mag   <= mag_next;
      neg   <= neg_next;
    end
  end

  assign speed = mag;
  assign ok    = (mag <= SPEED_MAX) && !(neg && (mag != '0));

endmodule

`default_nettype wire

@@ sv/mcld_duty_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mcld_duty_unit (
  input  wire logic                             clk,
  input  wire mcld_pkg::duty_ctrl_t             ctrl,
  input  wire logic [mcld_pkg::SPEED_W-1:0]     speed,
  input  wire logic [mcld_pkg::SCALE_W-1:0]     scale,
  output logic [mcld_pkg::DUTY_W-1:0]           duty
);
  import mcld_pkg::*;

  logic [PROD_W-1:0]         prod;
  logic [PROD_W+RECIP_W-1:0] scaled;

  // divide by ten through the reciprocal
  assign scaled = (PROD_W + RECIP_W)'(prod) * (PROD_W + RECIP_W)'(DIV10_RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PROD_W'(speed) * PROD_W'(scale);
    end
    if (ctrl.div_en) begin
      duty <= scaled[RECIP_SH +: DUTY_W];
    end
  end

endmodule

`default_nettype wire
